### rtl/ffwh_pkg.sv
// Shared types and constants for the first-fit word heap.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package ffwh_pkg;

  // Heap geometry
  localparam int HEAP_WORDS = 64;
  localparam int AW         = $clog2(HEAP_WORDS);      // word index width
  localparam int LW         = $clog2(HEAP_WORDS + 1);  // run / length counter width
  localparam logic [AW-1:0] LAST_WORD  = AW'(HEAP_WORDS - 1);
  localparam logic [6:0]    HEAP_SIZE7 = 7'(HEAP_WORDS);
  localparam logic [7:0]    RESET_BYTE = 8'd63;

  typedef enum logic [1:0] {
    FUNC_ALLOC  = 2'd0,
    FUNC_WRITE  = 2'd1,
    FUNC_READ   = 2'd2,
    FUNC_ADJUST = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_RANGE    = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]        func;
    logic [5:0]        block_sel;
    logic [6:0]        alloc_size;
    logic [7:0]        type_tag;
    logic [5:0]        offset;
    logic [6:0]        value_length;
    logic [7:0]        byte_in;
    logic signed [7:0] count_delta;
  } in_item_t;

  typedef struct packed {
    logic [5:0] address;
    logic [7:0] byte_out;
    logic [7:0] new_count;
    logic       last;
    logic [1:0] status;
  } out_item_t;

  // One heap word without its data byte
  typedef struct packed {
    logic [5:0] owner;
    logic [7:0] wtype;
    logic [7:0] count;
  } meta_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic decide;
    logic stamp;
    logic rd_issue;
    logic emit_single;
    logic emit_byte;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] func;
    logic       scan_stop;
    logic       alloc_ok;
    logic       hit;
    logic       stamp_last;
    logic       rd_last;
    logic       out_free;
  } dp_status_t;

endpackage

`default_nettype wire

### rtl/first_fit_word_heap.sv
// Top level of the first-fit word heap: controller plus datapath.
// Depends on ffwh_pkg, ffwh_ctrl and ffwh_dp.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                 Payload
// in        sink       in_valid_i / in_stall_o   in_data_i  (in_item_t)
// out       source     out_valid_o / out_stall_i out_data_o (out_item_t)
//
// Steps: a load, a scan over the heap words (one word a cycle), a decide;
//   then a read that finds its block does a memory read, then a transfer,
//   for each byte, and any other item stamps alloc_size words on a successful
//   allocate and then emits its result.
// Reset: asynchronous, active low; per-word valid bits clear at once so
//   every word reads as its reset value without a clearing pass.
// Stalls: results sit in an output register; the block keeps working on
//   the next item until it needs that register again.

module first_fit_word_heap import ffwh_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_item_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_data_o
);

  ctrl_cmd_t  cmd;
  dp_status_t st;

  // Sequencer: owns the input handshake and the per-item step order
  ffwh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  // Datapath: heap memories, scan state and the output register
  ffwh_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .st_o        (st),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

### rtl/ffwh_ctrl.sv
// Sequencer for the first-fit word heap: scan, decide, stamp, read and emit.
// Depends on ffwh_pkg; drives the datapath through ctrl_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module ffwh_ctrl import ffwh_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire dp_status_t st_i,
  output ctrl_cmd_t       cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_SCAN    = 7'b0000010,
    S_DECIDE  = 7'b0000100,
    S_STAMP   = 7'b0001000,
    S_EMIT    = 7'b0010000,
    S_RD_ADDR = 7'b0100000,
    S_RD_EMIT = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (st_i.scan_stop) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d      = S_EMIT;
        if (st_i.func == FUNC_ALLOC && st_i.alloc_ok) state_d = S_STAMP;
        if (st_i.func == FUNC_READ && st_i.hit)       state_d = S_RD_ADDR;
      end
      S_STAMP: begin
        cmd_o.stamp = 1'b1;
        if (st_i.stamp_last) state_d = S_EMIT;
      end
      S_EMIT: begin
        if (st_i.out_free) begin
          cmd_o.emit_single = 1'b1;
          state_d           = S_IDLE;
        end
      end
      S_RD_ADDR: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = S_RD_EMIT;
      end
      S_RD_EMIT: begin
        if (st_i.out_free) begin
          cmd_o.emit_byte = 1'b1;
          state_d         = st_i.rd_last ? S_IDLE : S_RD_ADDR;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

### rtl/ffwh_dp.sv
// Datapath of the first-fit word heap: word memories, scan registers,
// adjust arithmetic and the result register. Depends on ffwh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ffwh_dp import ffwh_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire ctrl_cmd_t cmd_i,
  output dp_status_t     st_o,
  input  wire in_item_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_data_o
);

  // Word storage; an entry never written reads as its reset value
  meta_t      meta_mem [HEAP_WORDS];
  logic [7:0] byte_mem [HEAP_WORDS];
  logic [HEAP_WORDS-1:0] meta_vld_q;
  logic [HEAP_WORDS-1:0] byte_vld_q;

  in_item_t       item_q;
  logic [AW-1:0]  raddr_q;
  logic [AW-1:0]  eaddr_q;
  logic           eval_q;
  meta_t          meta_rd_q;
  logic           meta_rd_vld_q;
  logic [7:0]     byte_rd_q;
  logic           byte_rd_vld_q;

  logic [LW-1:0]  run_q;
  logic [AW-1:0]  run_start_q;
  logic           alloc_ok_q;
  logic           hit_q;
  logic [AW-1:0]  start_q;
  logic [LW-1:0]  len_q;
  logic [7:0]     count0_q;
  logic [7:0]     type0_q;
  logic [LW-1:0]  k_q;

  logic           out_vld_q;
  out_item_t      out_q;

  meta_t          meta_eff;
  logic [7:0]     byte_eff;
  logic [LW-1:0]  run_next;
  logic           run_hit;
  logic           id_hit;
  logic           size_bad;
  logic           is_alloc;
  logic           scan_end;
  logic           scan_stop;
  logic           wr_ok;
  logic signed [9:0] adj_sum;
  logic [7:0]     adj_count;
  logic           meta_we;
  logic [AW-1:0]  meta_waddr;
  meta_t          meta_wdata;
  logic           byte_we;
  logic [AW-1:0]  byte_waddr;
  logic [AW-1:0]  byte_raddr;
  logic           out_free;
  out_item_t      single_res;

  always_comb begin
    meta_eff = meta_rd_q;
    if (!meta_rd_vld_q) begin
      meta_eff.owner = 6'(eaddr_q);
      meta_eff.wtype = '0;
      meta_eff.count = '0;
    end
  end
  assign byte_eff = byte_rd_vld_q ? byte_rd_q : RESET_BYTE;

  assign is_alloc = (item_q.func == FUNC_ALLOC);
  assign size_bad = (item_q.alloc_size == 7'd0) || (item_q.alloc_size > HEAP_SIZE7);
  assign run_next = (meta_eff.count == 8'd0) ? run_q + LW'(1) : '0;
  assign run_hit  = (7'(run_next) == item_q.alloc_size);
  assign id_hit   = (meta_eff.owner == item_q.block_sel) && (meta_eff.count != 8'd0);
  assign scan_end = eval_q && (eaddr_q == LAST_WORD);

  always_comb begin
    if (is_alloc) begin
      scan_stop = size_bad || (eval_q && run_hit) || scan_end;
    end else begin
      scan_stop = (eval_q && hit_q && !id_hit) || scan_end;
    end
  end

  assign wr_ok = (7'(item_q.offset) < item_q.value_length) &&
                 (7'(item_q.offset) < 7'(len_q));

  // Saturating count adjust
  assign adj_sum = $signed({2'b00, count0_q}) + 10'(item_q.count_delta);
  always_comb begin
    if (adj_sum < 10'sd0)        adj_count = 8'd0;
    else if (adj_sum > 10'sd255) adj_count = 8'd255;
    else                         adj_count = adj_sum[7:0];
  end

  assign out_free = !out_vld_q || !out_stall_i;

  assign st_o.func       = item_q.func;
  assign st_o.scan_stop  = scan_stop;
  assign st_o.alloc_ok   = alloc_ok_q;
  assign st_o.hit        = hit_q;
  assign st_o.stamp_last = ((7'(k_q) + 7'd1) == item_q.alloc_size);
  assign st_o.rd_last    = ((k_q + LW'(1)) == len_q);
  assign st_o.out_free   = out_free;

  // Memory write selection
  always_comb begin
    meta_we    = 1'b0;
    meta_waddr = start_q;
    meta_wdata = '{owner: item_q.block_sel, wtype: type0_q, count: adj_count};
    if (cmd_i.stamp) begin
      meta_we    = 1'b1;
      meta_waddr = run_start_q + k_q[AW-1:0];
      meta_wdata = '{owner: 6'(run_start_q), wtype: item_q.type_tag, count: 8'd1};
    end else if (cmd_i.decide && item_q.func == FUNC_ADJUST && hit_q) begin
      meta_we = 1'b1;
    end
  end

  assign byte_we    = cmd_i.decide && item_q.func == FUNC_WRITE && hit_q && wr_ok;
  assign byte_waddr = start_q + item_q.offset[AW-1:0];
  assign byte_raddr = start_q + k_q[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (meta_we) meta_mem[meta_waddr] <= meta_wdata;
    if (byte_we) byte_mem[byte_waddr] <= item_q.byte_in;
    if (cmd_i.scan) begin
      meta_rd_q     <= meta_mem[raddr_q];
      meta_rd_vld_q <= meta_vld_q[raddr_q];
      eaddr_q       <= raddr_q;
    end
    if (cmd_i.rd_issue) begin
      byte_rd_q     <= byte_mem[byte_raddr];
      byte_rd_vld_q <= byte_vld_q[byte_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta_vld_q <= '0;
      byte_vld_q <= '0;
    end else begin
      if (meta_we) meta_vld_q[meta_waddr] <= 1'b1;
      if (byte_we) byte_vld_q[byte_waddr] <= 1'b1;
    end
  end

  // Item and scan bookkeeping
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raddr_q     <= '0;
      eval_q      <= 1'b0;
      run_q       <= '0;
      run_start_q <= '0;
      alloc_ok_q  <= 1'b0;
      hit_q       <= 1'b0;
      start_q     <= '0;
      len_q       <= '0;
      count0_q    <= '0;
      type0_q     <= '0;
      k_q         <= '0;
    end else begin
      eval_q <= cmd_i.scan;
      if (cmd_i.load) begin
        raddr_q    <= '0;
        run_q      <= '0;
        alloc_ok_q <= 1'b0;
        hit_q      <= 1'b0;
        len_q      <= '0;
      end
      if (cmd_i.scan && raddr_q != LAST_WORD) begin
        raddr_q <= raddr_q + AW'(1);
      end
      if (cmd_i.scan && eval_q) begin
        if (is_alloc) begin
          run_q <= run_next;
          if (meta_eff.count == 8'd0 && run_q == '0) run_start_q <= eaddr_q;
          if (run_hit) alloc_ok_q <= 1'b1;
        end else if (id_hit) begin
          if (!hit_q) begin
            hit_q    <= 1'b1;
            start_q  <= eaddr_q;
            len_q    <= LW'(1);
            count0_q <= meta_eff.count;
            type0_q  <= meta_eff.wtype;
          end else begin
            len_q <= len_q + LW'(1);
          end
        end
      end
      if (cmd_i.decide) begin
        k_q <= '0;
      end else if (cmd_i.stamp || cmd_i.emit_byte) begin
        k_q <= k_q + LW'(1);
      end
    end
  end

  // Single-result assembly
  always_comb begin
    single_res      = '0;
    single_res.last = 1'b1;
    if (is_alloc) begin
      if (alloc_ok_q) begin
        single_res.address = 6'(run_start_q);
        single_res.status  = ST_OK;
      end else begin
        single_res.status  = ST_NO_SPACE;
      end
    end else if (!hit_q) begin
      single_res.status = ST_NOT_FOUND;
    end else if (item_q.func == FUNC_WRITE) begin
      single_res.status = wr_ok ? ST_OK : ST_RANGE;
    end else begin
      single_res.new_count = adj_count;
      single_res.status    = ST_OK;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      if (cmd_i.emit_single || cmd_i.emit_byte) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_single) begin
      out_q <= single_res;
    end else if (cmd_i.emit_byte) begin
      out_q <= '{address: 6'd0, byte_out: byte_eff, new_count: 8'd0,
                 last: st_o.rd_last, status: ST_OK};
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
